@@ rtl/vbs_pkg.sv @@
// Shared constants, codes and controller/datapath handshake structs
// for the packed voxel bit store. No dependencies.
`timescale 1ns / 1ps

package vbs_pkg;

  localparam int WORD_COUNT = 131072;
  localparam int ADDR_W     = $clog2(WORD_COUNT);
  localparam int DATA_W     = 32;
  localparam int COORD_W    = 10;
  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(256);

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_DEPTH  = CFG_IDX_W'(2);

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef struct packed {
    logic clear;
    logic load;
    logic mul1;
    logic mul2;
    logic addr;
    logic rd;
    logic finish;
  } vbs_cmd_t;

  typedef struct packed {
    logic clear_last;
  } vbs_sts_t;

endpackage

@@ rtl/packed_voxel_bit_store_unit.sv @@
// Top level of the packed voxel bit store: controller plus datapath.
// Depends on vbs_pkg, vbs_ctrl, vbs_datapath (and vbs_ram below it).
//
//   channel   handshake           payload
//   input     start / busy        in_command, in_coord_x/y/z, in_write_value
//   result    out_valid (strobe)  out_voxel_bit, out_out_of_range
//   config    cfg_we              cfg_index, cfg_data
//
// Each item passes from acceptance to its result strobe through two multiply
// steps, one address add and range check, then a single-port RAM read and, for in-range writes, a write.
// After reset a clearing pass writes zero to all 131072 words, one a cycle,
// with busy high; config writes are taken during it. Results cannot be stalled.
`timescale 1ns / 1ps

module packed_voxel_bit_store_unit import vbs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_command,
  input  logic [COORD_W-1:0]   in_coord_x,
  input  logic [COORD_W-1:0]   in_coord_y,
  input  logic [COORD_W-1:0]   in_coord_z,
  input  logic                 in_write_value,
  output logic                 out_valid,
  output logic                 out_voxel_bit,
  output logic                 out_out_of_range,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  vbs_cmd_t cmd;
  vbs_sts_t sts;

  vbs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  vbs_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_command       (in_command),
    .in_coord_x       (in_coord_x),
    .in_coord_y       (in_coord_y),
    .in_coord_z       (in_coord_z),
    .in_write_value   (in_write_value),
    .out_valid        (out_valid),
    .out_voxel_bit    (out_voxel_bit),
    .out_out_of_range (out_out_of_range)
  );

endmodule

@@ rtl/vbs_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module vbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     re,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wr_data;
    end
    if (re) begin
      rd_data_r <= mem[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/vbs_ctrl.sv @@
// Sequencer for the voxel store: clearing pass, address steps, read-modify-write.
// Depends on vbs_pkg.
`timescale 1ns / 1ps

module vbs_ctrl import vbs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output vbs_cmd_t cmd,
  input  vbs_sts_t sts
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_ADDR,
    ST_READ,
    ST_WAIT
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (sts.clear_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (start) state_nxt = ST_MUL1;
      ST_MUL1:  state_nxt = ST_MUL2;
      ST_MUL2:  state_nxt = ST_ADDR;
      ST_ADDR:  state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_WAIT;
      ST_WAIT:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      busy_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != ST_IDLE);
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.clear  = (state_r == ST_CLEAR);
    cmd.load   = (state_r == ST_IDLE) && start;
    cmd.mul1   = (state_r == ST_MUL1);
    cmd.mul2   = (state_r == ST_MUL2);
    cmd.addr   = (state_r == ST_ADDR);
    cmd.rd     = (state_r == ST_READ);
    cmd.finish = (state_r == ST_WAIT);
  end

  assign busy = busy_r;

endmodule

@@ rtl/vbs_datapath.sv @@
// Datapath: size registers, brick address arithmetic, range check,
// voxel word RAM with read-modify-write and the result register.
// Depends on vbs_pkg and vbs_ram.
`timescale 1ns / 1ps

module vbs_datapath import vbs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  vbs_cmd_t             cmd,
  output vbs_sts_t             sts,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_command,
  input  logic [COORD_W-1:0]   in_coord_x,
  input  logic [COORD_W-1:0]   in_coord_y,
  input  logic [COORD_W-1:0]   in_coord_z,
  input  logic                 in_write_value,
  output logic                 out_valid,
  output logic                 out_voxel_bit,
  output logic                 out_out_of_range
);

  localparam int STRIDE_W = CFG_W - 1;
  localparam int BLK_W    = COORD_W - 2;
  localparam int P1_W     = BLK_W + STRIDE_W;
  localparam int P2_W     = 2 * STRIDE_W;
  localparam int P3_W     = BLK_W + P2_W;
  localparam int BRICK_W  = P3_W + 1;
  localparam int WORD_W   = BRICK_W + 1;
  localparam logic [ADDR_W-1:0] CLEAR_LAST = ADDR_W'(WORD_COUNT - 1);

  logic [CFG_W-1:0]   width_r, height_r, depth_r;
  logic               command_r, wv_r;
  logic [COORD_W-1:0] x_r, y_r, z_r;
  logic [P1_W-1:0]    p1_r;
  logic [P2_W-1:0]    p2_r;
  logic [P3_W-1:0]    p3_r;
  logic [WORD_W-1:0]  word_r;
  logic               bad_r;
  logic [ADDR_W-1:0]  clr_cnt_r;
  logic               out_valid_r, out_bit_r, out_bad_r;

  logic [STRIDE_W-1:0] xs, ys;
  logic [BRICK_W-1:0]  brick;
  logic [WORD_W-1:0]   word_nxt;
  logic                bad_nxt;
  logic [4:0]          bit_idx;
  logic [DATA_W-1:0]   mask, rd_data, mod_data, ram_wr_data;
  logic [ADDR_W-1:0]   ram_addr;
  logic                ram_we, old_bit;

  assign xs = STRIDE_W'(width_r[CFG_W-1:2]) + STRIDE_W'(1);
  assign ys = STRIDE_W'(height_r[CFG_W-1:2]) + STRIDE_W'(1);

  assign brick = BRICK_W'(x_r[COORD_W-1:2]) + BRICK_W'(p1_r) + BRICK_W'(p3_r);
  assign word_nxt = {brick, z_r[1]};
  assign bad_nxt = ({1'b0, x_r} >= width_r) || ({1'b0, y_r} >= height_r)
                || ({1'b0, z_r} >= depth_r) || (word_nxt >= WORD_W'(WORD_COUNT));

  assign bit_idx  = {z_r[0], y_r[1:0], x_r[1:0]};
  assign mask     = DATA_W'(1) << bit_idx;
  assign old_bit  = rd_data[bit_idx];
  assign mod_data = wv_r ? (rd_data | mask) : (rd_data & ~mask);

  assign ram_addr    = cmd.clear ? clr_cnt_r : word_r[ADDR_W-1:0];
  assign ram_we      = cmd.clear || (cmd.finish && !bad_r && (command_r == CMD_WRITE));
  assign ram_wr_data = cmd.clear ? '0 : mod_data;

  vbs_ram #(
    .WIDTH(DATA_W),
    .DEPTH(WORD_COUNT)
  ) u_ram (
    .clk     (clk),
    .addr    (ram_addr),
    .we      (ram_we),
    .wr_data (ram_wr_data),
    .re      (cmd.rd),
    .rd_data (rd_data)
  );

  assign sts.clear_last = (clr_cnt_r == CLEAR_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= CFG_RESET;
      height_r    <= CFG_RESET;
      depth_r     <= CFG_RESET;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  width_r  <= cfg_data;
          REG_IMAGE_HEIGHT: height_r <= cfg_data;
          REG_IMAGE_DEPTH:  depth_r  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.clear) begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      end
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      command_r <= in_command;
      wv_r      <= in_write_value;
      x_r       <= in_coord_x;
      y_r       <= in_coord_y;
      z_r       <= in_coord_z;
    end
    if (cmd.mul1) begin
      p1_r <= P1_W'(y_r[COORD_W-1:2]) * P1_W'(xs);
      p2_r <= P2_W'(xs) * P2_W'(ys);
    end
    if (cmd.mul2) begin
      p3_r <= P3_W'(z_r[COORD_W-1:2]) * P3_W'(p2_r);
    end
    if (cmd.addr) begin
      word_r <= word_nxt;
      bad_r  <= bad_nxt;
    end
    if (cmd.finish) begin
      out_bad_r <= bad_r;
      out_bit_r <= bad_r ? 1'b0 : ((command_r == CMD_WRITE) ? wv_r : old_bit);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_voxel_bit    = out_bit_r;
  assign out_out_of_range = out_bad_r;

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for packed_voxel_bit_store_unit: directed table, then random phases.
// Predicts untyped results from its brick-packed voxel memory; depends on vbs_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
  import vbs_pkg::*;

  typedef struct {
    logic               cmd;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic               wv;
    bit                 typed;
    logic               exp_vbit;
    logic               exp_oor;
  } probe_t;

  typedef struct {
    logic vbit;
    logic oor;
  } voxel_result_t;

  typedef struct {
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] h;
    logic [CFG_W-1:0] d;
    int               idle_pct;
    int               count;
  } phase_t;

  localparam int PROBE_COUNT = 24;
  localparam int PHASE_COUNT = 7;
  localparam int POOL_DEPTH  = 16;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_command = CMD_READ;
  logic [COORD_W-1:0] in_coord_x = '0;
  logic [COORD_W-1:0] in_coord_y = '0;
  logic [COORD_W-1:0] in_coord_z = '0;
  logic               in_write_value = 1'b0;
  logic               out_valid;
  logic               out_voxel_bit;
  logic               out_out_of_range;
  logic               cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_W-1:0]   cfg_data = '0;

  logic [DATA_W-1:0]  voxel_mem [WORD_COUNT];
  logic [CFG_W-1:0]   img_width;
  logic [CFG_W-1:0]   img_height;
  logic [CFG_W-1:0]   img_depth;
  voxel_result_t      pending_results [$];
  probe_t             written_pool [$];
  voxel_result_t      head_r;
  int                 fail_count = 0;

  probe_t probe_table [PROBE_COUNT] = '{
    '{CMD_READ,    0,    0,    0, 1'b0, 1, 1'b0, 1'b0},
    '{CMD_WRITE,   0,    0,    0, 1'b1, 1, 1'b1, 1'b0},
    '{CMD_READ,    0,    0,    0, 1'b0, 1, 1'b1, 1'b0},
    '{CMD_WRITE, 255,  255,  255, 1'b1, 1, 1'b0, 1'b1},
    '{CMD_READ,  255,  255,  255, 1'b1, 1, 1'b0, 1'b1},
    '{CMD_READ,  256,    0,    0, 1'b0, 1, 1'b0, 1'b1},
    '{CMD_READ,    0,  256,    0, 1'b0, 1, 1'b0, 1'b1},
    '{CMD_READ,    0,    0,  256, 1'b0, 1, 1'b0, 1'b1},
    '{CMD_WRITE, 1023, 1023, 1023, 1'b1, 1, 1'b0, 1'b1},
    '{CMD_READ,  1023, 1023, 1023, 1'b0, 1, 1'b0, 1'b1},
    '{CMD_WRITE,   0,    0,    0, 1'b0, 1, 1'b0, 1'b0},
    '{CMD_READ,    0,    0,    0, 1'b1, 1, 1'b0, 1'b0},
    '{CMD_WRITE,   3,    3,    3, 1'b0, 1, 1'b0, 1'b0},
    '{CMD_WRITE,   1,    2,    1, 1'b1, 1, 1'b1, 1'b0},
    '{CMD_WRITE,   1,    2,    1, 1'b1, 1, 1'b1, 1'b0},
    '{CMD_READ,    1,    2,    1, 1'b0, 0, 1'b0, 1'b0},
    '{CMD_WRITE,   2,    1,    0, 1'b1, 0, 1'b0, 1'b0},
    '{CMD_READ,    2,    1,    0, 1'b0, 0, 1'b0, 1'b0},
    '{CMD_READ,    1,    2,    1, 1'b1, 0, 1'b0, 1'b0},
    '{CMD_WRITE,   4,    0,    2, 1'b1, 0, 1'b0, 1'b0},
    '{CMD_READ,    4,    0,    3, 1'b0, 0, 1'b0, 1'b0},
    '{CMD_READ,    4,    0,    2, 1'b0, 0, 1'b0, 1'b0},
    '{CMD_WRITE, 170,   85,  170, 1'b1, 0, 1'b0, 1'b0},
    '{CMD_READ,  682,  341,  682, 1'b1, 1, 1'b0, 1'b1}
  };

  phase_t phase_table [PHASE_COUNT] = '{
    '{11'd64,   11'd32,   11'd16,   0,  150},
    '{11'd1024, 11'd1024, 11'd1024, 46, 120},
    '{11'd1,    11'd1,    11'd1,    0,  50},
    '{11'd2047, 11'd5,    11'd300,  27, 100},
    '{11'd0,    11'd17,   11'd17,   46, 40},
    '{11'd100,  11'd100,  11'd7,    0,  150},
    '{11'd9,    11'd0,    11'd2047, 27, 40}
  };

  packed_voxel_bit_store_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_coord_x       (in_coord_x),
    .in_coord_y       (in_coord_y),
    .in_coord_z       (in_coord_z),
    .in_write_value   (in_write_value),
    .out_valid        (out_valid),
    .out_voxel_bit    (out_voxel_bit),
    .out_out_of_range (out_out_of_range),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic voxel_result_t access_voxel(input probe_t pr);
    logic [63:0]   xs;
    logic [63:0]   ys;
    logic [63:0]   brick;
    logic [63:0]   word_idx;
    logic [4:0]    bit_pos;
    logic          bad;
    voxel_result_t r;
    xs = 64'(img_width >> 2) + 64'd1;
    ys = 64'(img_height >> 2) + 64'd1;
    brick = 64'(pr.x >> 2) + 64'(pr.y >> 2) * xs + 64'(pr.z >> 2) * xs * ys;
    word_idx = brick * 64'd2 + 64'(pr.z[1]);
    bit_pos = {pr.z[0], pr.y[1:0], pr.x[1:0]};
    bad = (11'(pr.x) >= img_width) || (11'(pr.y) >= img_height) ||
          (11'(pr.z) >= img_depth) || (word_idx >= 64'(WORD_COUNT));
    r.vbit = 1'b0;
    r.oor = bad;
    if (!bad) begin
      if (pr.cmd == CMD_WRITE) begin
        voxel_mem[word_idx][bit_pos] = pr.wv;
        r.vbit = pr.wv;
      end else begin
        r.vbit = voxel_mem[word_idx][bit_pos];
      end
    end
    return r;
  endfunction

  // caller is at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input probe_t pr);
    voxel_result_t r;
    start = 1'b1;
    in_command = pr.cmd;
    in_coord_x = pr.x;
    in_coord_y = pr.y;
    in_coord_z = pr.z;
    in_write_value = pr.wv;
    do @(posedge clk); while (busy);
    r = access_voxel(pr);
    if (pr.typed) begin
      r.vbit = pr.exp_vbit;
      r.oor = pr.exp_oor;
    end
    pending_results = {pending_results, r};
    if (pr.cmd == CMD_WRITE) begin
      written_pool = {written_pool, pr};
      if (written_pool.size() > POOL_DEPTH) void'(written_pool.pop_front());
    end
    @(negedge clk);
  endtask

  task automatic idle_sender(input int idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      in_command = 1'($urandom);
      in_coord_x = COORD_W'($urandom);
      in_coord_y = COORD_W'($urandom);
      in_coord_z = COORD_W'($urandom);
      in_write_value = 1'($urandom);
      @(negedge clk);
      while ($urandom_range(99) < idle_pct) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_dims(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                            input logic [CFG_W-1:0] d);
    cfg_we = 1'b1;
    cfg_index = REG_IMAGE_WIDTH;
    cfg_data = w;
    @(negedge clk);
    cfg_index = REG_IMAGE_HEIGHT;
    cfg_data = h;
    @(negedge clk);
    cfg_index = REG_IMAGE_DEPTH;
    cfg_data = d;
    @(negedge clk);
    cfg_we = 1'b0;
    img_width = w;
    img_height = h;
    img_depth = d;
  endtask

  function automatic logic [COORD_W-1:0] pick_coord(input logic [CFG_W-1:0] dim);
    int unsigned lim;
    int unsigned sel;
    lim = (dim > 11'd1024) ? 1024 : int'(dim);
    sel = $urandom_range(9);
    if (sel < 7 && lim > 0) return COORD_W'($urandom_range(lim - 1));
    if (sel == 7) return COORD_W'($urandom);
    if (sel == 8) begin
      case ($urandom_range(3))
        0: return '0;
        1: return COORD_W'(lim - 1);
        2: return COORD_W'(lim);
        default: return '1;
      endcase
    end
    return '1;
  endfunction

  function automatic probe_t random_probe();
    probe_t pr;
    if (written_pool.size() > 0 && $urandom_range(2) == 0) begin
      pr = written_pool[$urandom_range(written_pool.size() - 1)];
      // reuse a recent voxel or a neighbor in the same brick
      if ($urandom_range(1) == 0) pr.x[1:0] = 2'($urandom);
      if ($urandom_range(1) == 0) pr.z[0] = 1'($urandom);
    end else begin
      pr.x = pick_coord(img_width);
      pr.y = pick_coord(img_height);
      pr.z = pick_coord(img_depth);
    end
    pr.cmd = 1'($urandom);
    pr.wv = 1'($urandom);
    pr.typed = 0;
    pr.exp_vbit = 1'b0;
    pr.exp_oor = 1'b0;
    return pr;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: voxel_bit=%0b out_of_range=%0b",
               out_voxel_bit, out_out_of_range);
        fail_count++;
      end else begin
        head_r = pending_results.pop_front();
        if (out_voxel_bit !== head_r.vbit) begin
          $error("voxel_bit mismatch: expected %0b, actual %0b", head_r.vbit, out_voxel_bit);
          fail_count++;
        end
        if (out_out_of_range !== head_r.oor) begin
          $error("out_of_range mismatch: expected %0b, actual %0b",
                 head_r.oor, out_out_of_range);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #8_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    foreach (voxel_mem[i]) voxel_mem[i] = '0;
    img_width = CFG_RESET;
    img_height = CFG_RESET;
    img_depth = CFG_RESET;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    foreach (probe_table[i]) send_item(probe_table[i]);
    drain_results();

    foreach (phase_table[p]) begin
      drain_results();
      write_dims(phase_table[p].w, phase_table[p].h, phase_table[p].d);
      repeat (phase_table[p].count) begin
        send_item(random_probe());
        idle_sender(phase_table[p].idle_pct);
      end
    end

    drain_results();
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
